@@ rtl/rcid_pkg.sv @@
package rcid_pkg;

  // operation codes carried in the low bits of the input item
  localparam logic [2:0] OP_ALLOC = 3'd0;
  localparam logic [2:0] OP_INC   = 3'd1;
  localparam logic [2:0] OP_ADD   = 3'd2;
  localparam logic [2:0] OP_DEC   = 3'd3;
  localparam logic [2:0] OP_SUB   = 3'd4;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_LIMIT = 2'd2;

  // fixed field widths of the item formats
  localparam int OP_W     = 3;
  localparam int ID_W     = 6;
  localparam int AMT_W    = 16;
  localparam int STATUS_W = 2;
  localparam int POOL_W   = 7;

  // pool size after reset
  localparam logic [POOL_W-1:0] POOL_RESET = 7'd64;

  // sequencer states
  typedef enum logic [4:0] {
    S_CLEAR  = 5'b00001,
    S_IDLE   = 5'b00010,
    S_SCAN   = 5'b00100,
    S_MODIFY = 5'b01000,
    S_DONE   = 5'b10000
  } state_t;

endpackage

@@ rtl/refcount_id_allocator.sv @@
// Pool of IDs with a saturating reference count per ID, held in one synchronous
// RAM. After reset the block clears the count RAM, one entry per cycle, and
// accepts no item until that is done (pool size writes are taken at any time).
// Increment, add, decrement and subtract go through a RAM read, then modify and
// write back, then the output register. An unused operation code or a target
// outside the pool goes straight to the output register. Allocate scans the RAM
// one entry per cycle from the search hint until it finds a free ID or has read
// every entry of the pool. One item is in work at a time; a finished result
// waits in the output register and the block can take the next item meanwhile.
module refcount_id_allocator #(
  parameter int MAX_POOL   = 64,
  parameter int COUNT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  // input item: operation [2:0], target_id [8:3], amount [24:9], zero fill
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,
  // result item: granted_id [5:0], status [7:6]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,
  // pool size register
  input  logic        cfg_we,
  input  logic [6:0]  cfg_wdata
);

  localparam int AW   = $clog2(MAX_POOL);
  localparam int SW   = (AW + 1 > rcid_pkg::POOL_W) ? AW + 1 : rcid_pkg::POOL_W;
  localparam int SUMW = ((COUNT_BITS > rcid_pkg::AMT_W) ? COUNT_BITS : rcid_pkg::AMT_W) + 1;
  localparam logic [SW-1:0]         POOL_MAX  = SW'(MAX_POOL);
  localparam logic [AW-1:0]         LAST_ADDR = AW'(MAX_POOL - 1);
  localparam logic [COUNT_BITS-1:0] CNT_MAX   = {COUNT_BITS{1'b1}};

  rcid_pkg::state_t state;

  logic [rcid_pkg::POOL_W-1:0] pool_size;
  logic [AW-1:0]               hint;
  logic [AW-1:0]               clr_addr;

  // captured item
  logic [rcid_pkg::OP_W-1:0]  op_q;
  logic [AW-1:0]              id_q;
  logic [rcid_pkg::AMT_W-1:0] amt_q;

  // scan bookkeeping
  logic [AW-1:0] scan_addr;
  logic [SW-1:0] n_issue;
  logic          pend;
  logic [AW-1:0] pend_pos;

  // result waiting for the output register
  logic [AW-1:0]                 res_granted;
  logic [rcid_pkg::STATUS_W-1:0] res_status;

  // ram ports
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [COUNT_BITS-1:0] wr_data;
  logic                  rd_en;
  logic [AW-1:0]         rd_addr;
  logic [COUNT_BITS-1:0] rd_data;

  // input field decode
  logic [rcid_pkg::OP_W-1:0]  in_op;
  logic [rcid_pkg::ID_W-1:0]  in_id;
  logic [rcid_pkg::AMT_W-1:0] in_amt;
  logic [SW-1:0]              in_id_ext;
  logic                       accept;
  logic                       in_modify;

  assign in_op     = s_tdata[2:0];
  assign in_id     = s_tdata[8:3];
  assign in_amt    = s_tdata[24:9];
  assign in_id_ext = SW'(in_id);
  assign s_tready  = (state == rcid_pkg::S_IDLE);
  assign accept    = s_tvalid && s_tready;

  // effective pool size
  logic [SW-1:0] pool_ext;
  logic [SW-1:0] size;
  assign pool_ext = SW'(pool_size);
  assign size     = (pool_ext == '0 || pool_ext > POOL_MAX) ? POOL_MAX : pool_ext;

  assign in_modify = (in_op == rcid_pkg::OP_INC || in_op == rcid_pkg::OP_ADD ||
                      in_op == rcid_pkg::OP_DEC || in_op == rcid_pkg::OP_SUB) &&
                     (in_id_ext < size);

  // scan step
  logic          issue;
  logic          found;
  logic [SW-1:0] scan_inc;
  logic [SW-1:0] pend_inc;
  logic [SW-1:0] hint_ext;
  assign issue    = (n_issue < size);
  assign found    = pend && (rd_data == '0);
  assign scan_inc = SW'(scan_addr) + SW'(1);
  assign pend_inc = SW'(pend_pos) + SW'(1);
  assign hint_ext = SW'(hint);

  // count update for the modify step
  logic [SUMW-1:0]       cnt_ext;
  logic [SUMW-1:0]       delta;
  logic [SUMW-1:0]       sum;
  logic [SUMW-1:0]       diff;
  logic                  is_add;
  logic [COUNT_BITS-1:0] new_cnt;
  logic [rcid_pkg::STATUS_W-1:0] mod_status;
  logic                  to_zero;

  assign cnt_ext = SUMW'(rd_data);
  assign is_add  = (op_q == rcid_pkg::OP_INC || op_q == rcid_pkg::OP_ADD);
  assign delta   = (op_q == rcid_pkg::OP_INC || op_q == rcid_pkg::OP_DEC) ?
                   SUMW'(1) : SUMW'(amt_q);
  assign sum     = cnt_ext + delta;
  assign diff    = cnt_ext - delta;

  always_comb begin
    new_cnt    = '0;
    mod_status = rcid_pkg::ST_OK;
    to_zero    = 1'b0;
    if (is_add) begin
      if (sum > SUMW'(CNT_MAX)) begin
        new_cnt    = CNT_MAX;
        mod_status = rcid_pkg::ST_LIMIT;
      end else begin
        new_cnt = sum[COUNT_BITS-1:0];
      end
    end else if (delta >= cnt_ext) begin
      to_zero = 1'b1;
      if (delta > cnt_ext) begin
        mod_status = rcid_pkg::ST_LIMIT;
      end
    end else begin
      new_cnt = diff[COUNT_BITS-1:0];
    end
  end

  // ram port selection
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = clr_addr;
    wr_data = '0;
    if (state == rcid_pkg::S_CLEAR) begin
      wr_en = 1'b1;
    end else if (state == rcid_pkg::S_MODIFY) begin
      wr_en   = 1'b1;
      wr_addr = id_q;
      wr_data = new_cnt;
    end
  end

  assign rd_en   = (accept && in_modify) || (state == rcid_pkg::S_SCAN && issue);
  assign rd_addr = (state == rcid_pkg::S_SCAN) ? scan_addr : in_id_ext[AW-1:0];

  rcid_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (MAX_POOL)
  ) u_counts (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // pool size register
  always_ff @(posedge clk) begin
    if (rst) begin
      pool_size <= rcid_pkg::POOL_RESET;
    end else if (cfg_we) begin
      pool_size <= cfg_wdata;
    end
  end

  // sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= rcid_pkg::S_CLEAR;
      clr_addr <= '0;
      hint     <= '0;
      pend     <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      // output valid: set when the done step loads, cleared on handshake
      if (state == rcid_pkg::S_DONE && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        rcid_pkg::S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == LAST_ADDR) begin
            state <= rcid_pkg::S_IDLE;
          end
        end
        rcid_pkg::S_IDLE: begin
          if (accept) begin
            pend <= 1'b0;
            if (in_op == rcid_pkg::OP_ALLOC) begin
              state <= rcid_pkg::S_SCAN;
            end else if (in_modify) begin
              state <= rcid_pkg::S_MODIFY;
            end else begin
              state <= rcid_pkg::S_DONE;
            end
          end
        end
        rcid_pkg::S_SCAN: begin
          if (found) begin
            hint  <= (pend_inc < size) ? pend_inc[AW-1:0] : '0;
            pend  <= 1'b0;
            state <= rcid_pkg::S_DONE;
          end else if (!issue) begin
            pend  <= 1'b0;
            state <= rcid_pkg::S_DONE;
          end else begin
            pend <= 1'b1;
          end
        end
        rcid_pkg::S_MODIFY: begin
          if (!is_add && to_zero) begin
            hint <= id_q;
          end
          state <= rcid_pkg::S_DONE;
        end
        rcid_pkg::S_DONE: begin
          if (!m_tvalid || m_tready) begin
            state <= rcid_pkg::S_IDLE;
          end
        end
        default: state <= rcid_pkg::S_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    // capture the item and set up the scan
    if (accept) begin
      op_q        <= in_op;
      id_q        <= in_id_ext[AW-1:0];
      amt_q       <= in_amt;
      scan_addr   <= (hint_ext < size) ? hint : '0;
      n_issue     <= '0;
      res_granted <= '0;
      res_status  <= rcid_pkg::ST_OK;
    end
    // walk the pool one entry per cycle
    if (state == rcid_pkg::S_SCAN) begin
      if (found) begin
        res_granted <= pend_pos;
        res_status  <= rcid_pkg::ST_OK;
      end else if (!issue) begin
        res_granted <= '0;
        res_status  <= rcid_pkg::ST_FULL;
      end else begin
        pend_pos  <= scan_addr;
        scan_addr <= (scan_inc < size) ? scan_inc[AW-1:0] : '0;
        n_issue   <= n_issue + SW'(1);
      end
    end
    if (state == rcid_pkg::S_MODIFY) begin
      res_status <= mod_status;
    end
    // output register load
    if (state == rcid_pkg::S_DONE && (!m_tvalid || m_tready)) begin
      m_tdata <= {res_status, 6'(res_granted)};
    end
  end

  // no new item while one is in work
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    accept |=> !s_tready)
    else $error("item accepted while another is in work");

  // a full pool grants no id
  a_full_no_grant: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[7:6] == rcid_pkg::ST_FULL) |-> (m_tdata[5:0] == 6'd0))
    else $error("pool full but an id was granted");

  // status code is one of the defined ones
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[7:6] == rcid_pkg::ST_OK || m_tdata[7:6] == rcid_pkg::ST_FULL ||
                  m_tdata[7:6] == rcid_pkg::ST_LIMIT))
    else $error("undefined status code");

  // the hint always points into the ram
  a_hint_range: assert property (@(posedge clk) disable iff (rst)
    SW'(hint) < POOL_MAX)
    else $error("search hint beyond the pool");

  // a scan read is only ever taken from inside the effective pool
  a_scan_range: assert property (@(posedge clk) disable iff (rst)
    (state == rcid_pkg::S_SCAN && issue) |-> (SW'(scan_addr) < size))
    else $error("scan address beyond the pool size");

endmodule

@@ rtl/rcid_ram.sv @@
module rcid_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

  localparam int MAX_POOL = 64;
  localparam logic [15:0] COUNT_MAX = 16'hFFFF;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int PHASE_ITEMS = 190;
  localparam logic [6:0] POOL_PLAN [10] = '{7'd64, 7'd1, 7'd2, 7'd5, 7'd16,
                                           7'd33, 7'd0, 7'd127, 7'd63, 7'd64};

  // result item layout: granted_id in the low bits, status above it
  typedef struct packed {
    logic [1:0] status;
    logic [5:0] granted;
  } result_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;   // operation [2:0], target_id [8:3], amount [24:9], zero fill
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;   // granted_id [5:0], status [7:6]
  logic        cfg_we;
  logic [6:0]  cfg_wdata;

  // shadow copy of the allocator state
  logic [15:0] id_refcount [MAX_POOL];
  logic [5:0]  alloc_hint;
  logic [6:0]  pool_cfg;

  result_t result_q [$];
  result_t last_result;
  int      err_count = 0;
  int      cycles = 0;
  int      hold_off_cycles = 0;
  bit      idle_on = 1'b1;

  refcount_id_allocator #(
    .MAX_POOL  (64),
    .COUNT_BITS(16)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always #6 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    $display("ERROR at %0t: %s", $time, what);
    err_count++;
  endtask

  function automatic int pool_eff();
    return (pool_cfg == 7'd0 || pool_cfg > 7'(MAX_POOL)) ? MAX_POOL : int'(pool_cfg);
  endfunction

  // expected result of one item, updating the shadow state
  function automatic result_t allocator_step(input logic [2:0] op, input logic [5:0] id,
                                             input logic [15:0] amt);
    result_t r;
    int size;
    int pos;
    bit found;
    logic [16:0] sum;
    logic [15:0] cur;
    logic [15:0] dec_by;
    r.granted = '0;
    r.status = rcid_pkg::ST_OK;
    size = pool_eff();
    found = 1'b0;
    if (op == rcid_pkg::OP_ALLOC) begin
      // scan from the hint, wrapping at the pool size
      pos = (int'(alloc_hint) < size) ? int'(alloc_hint) : 0;
      for (int n = 0; n < size && !found; n++) begin
        if (id_refcount[pos] == '0) found = 1'b1;
        else pos = (pos + 1 >= size) ? 0 : pos + 1;
      end
      if (found) begin
        r.granted = 6'(pos);
        alloc_hint = (pos + 1 < size) ? 6'(pos + 1) : 6'd0;
      end else begin
        r.status = rcid_pkg::ST_FULL;
      end
    end else if (op <= rcid_pkg::OP_SUB && int'(id) < size) begin
      cur = id_refcount[id];
      if (op == rcid_pkg::OP_INC || op == rcid_pkg::OP_ADD) begin
        sum = {1'b0, cur} + ((op == rcid_pkg::OP_INC) ? 17'd1 : {1'b0, amt});
        if (sum > {1'b0, COUNT_MAX}) begin
          id_refcount[id] = COUNT_MAX;
          r.status = rcid_pkg::ST_LIMIT;
        end else begin
          id_refcount[id] = sum[15:0];
        end
      end else begin
        dec_by = (op == rcid_pkg::OP_DEC) ? 16'd1 : amt;
        if (dec_by >= cur) begin
          if (dec_by > cur) r.status = rcid_pkg::ST_LIMIT;
          id_refcount[id] = '0;
          alloc_hint = id;
        end else begin
          id_refcount[id] = cur - dec_by;
        end
      end
    end
    return r;
  endfunction

  // offer one item; called at a falling edge, returns at a falling edge
  // with valid still high so back-to-back items need no extra step
  task automatic send_item(input logic [2:0] op, input logic [5:0] id,
                           input logic [15:0] amt);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {7'd0, amt, id, op};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    last_result = allocator_step(op, id, amt);
    result_q.push_back(last_result);
    @(negedge clk);
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (result_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_pool_size(input logic [6:0] value);
    drain_results();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    pool_cfg = value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // result checker
  always @(posedge clk) begin : check_results
    result_t got;
    result_t want;
    if (m_tvalid && m_tready) begin
      got = result_t'(m_tdata);
      if (result_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result id=%0d status=%0d",
                                  got.granted, got.status));
      end else begin
        want = result_q.pop_front();
        if (got.granted != want.granted)
          report_mismatch($sformatf("granted_id %0d, expected %0d", got.granted, want.granted));
        if (got.status != want.status)
          report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
      end
    end
  end

  // receiver: random stall bursts plus a long hold-off on request
  initial begin : ready_driver
    int stall_left;
    stall_left = 0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_cycles > 0) begin
        m_tready <= 1'b0;
        hold_off_cycles--;
      end else if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        m_tready <= 1'b0;
        stall_left = $urandom_range(0, 5);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // allocation, saturation, clamping and unused codes at full pool size
  task automatic test_directed_basics();
    send_item(rcid_pkg::OP_ALLOC, 6'd63, 16'hFFFF);
    send_item(rcid_pkg::OP_ALLOC, 6'd0, 16'd0);
    send_item(rcid_pkg::OP_INC, 6'd0, 16'd0);
    send_item(rcid_pkg::OP_ADD, 6'd0, 16'hFFFE);
    send_item(rcid_pkg::OP_INC, 6'd0, 16'd0);
    send_item(rcid_pkg::OP_ADD, 6'd5, 16'hFFFF);
    send_item(rcid_pkg::OP_ADD, 6'd5, 16'd1);
    send_item(rcid_pkg::OP_SUB, 6'd0, 16'hFFFF);
    send_item(rcid_pkg::OP_DEC, 6'd0, 16'd0);
    send_item(rcid_pkg::OP_SUB, 6'd63, 16'd0);
    send_item(rcid_pkg::OP_ALLOC, 6'd0, 16'd0);
    send_item(rcid_pkg::OP_SUB + 3'd1, 6'd63, 16'hFFFF);
    send_item(rcid_pkg::OP_SUB + 3'd2, 6'd0, 16'd0);
    send_item(rcid_pkg::OP_SUB + 3'd3, 6'd42, 16'h5A5A);
    send_item(rcid_pkg::OP_SUB, 6'd5, 16'hFFFF);
  endtask

  // hint past a shrunk pool, full pool, targets outside it, odd sizes
  task automatic test_pool_limits();
    send_item(rcid_pkg::OP_DEC, 6'd40, 16'd0);
    write_pool_size(7'd4);
    send_item(rcid_pkg::OP_ALLOC, 6'd0, 16'd0);
    for (int i = 0; i < 4; i++) send_item(rcid_pkg::OP_INC, 6'(i), 16'd0);
    send_item(rcid_pkg::OP_ALLOC, 6'd0, 16'd0);
    send_item(rcid_pkg::OP_INC, 6'd10, 16'd0);
    write_pool_size(7'd1);
    send_item(rcid_pkg::OP_ALLOC, 6'd0, 16'd0);
    send_item(rcid_pkg::OP_SUB, 6'd0, 16'hFFFF);
    send_item(rcid_pkg::OP_ALLOC, 6'd0, 16'd0);
    write_pool_size(7'd0);
    send_item(rcid_pkg::OP_ALLOC, 6'd0, 16'd0);
    write_pool_size(7'd127);
    send_item(rcid_pkg::OP_ALLOC, 6'd0, 16'd0);
    write_pool_size(7'd65);
    send_item(rcid_pkg::OP_INC, 6'd63, 16'd0);
    write_pool_size(7'd64);
  endtask

  // receiver holds off long enough for the block to stall its input
  task automatic test_backpressure();
    hold_off_cycles = 200;
    for (int i = 0; i < 24; i++) begin
      if (i % 3 == 0) send_item(rcid_pkg::OP_ALLOC, 6'($urandom), 16'($urandom));
      else send_item(rcid_pkg::OP_INC, 6'($urandom), 16'($urandom));
    end
    drain_results();
  endtask

  // one random phase at a given pool size
  task automatic run_random_phase(input logic [6:0] pool_val, input int n_items);
    int sent;
    int roll;
    int size;
    logic [5:0] id;
    logic [15:0] amt;
    logic [15:0] cur;
    write_pool_size(pool_val);
    size = pool_eff();
    sent = 0;
    while (sent < n_items) begin
      roll = $urandom_range(0, 99);
      id = ($urandom_range(0, 9) == 0) ? 6'($urandom) : 6'($urandom_range(0, size - 1));
      cur = id_refcount[id];
      if (roll < 30) begin
        // allocate, then usually take a reference on the granted id
        send_item(rcid_pkg::OP_ALLOC, 6'($urandom), 16'($urandom));
        sent++;
        if (last_result.status == rcid_pkg::ST_OK && $urandom_range(0, 4) != 0) begin
          send_item(rcid_pkg::OP_INC, last_result.granted, 16'($urandom));
          sent++;
        end
      end else if (roll < 48) begin
        send_item(rcid_pkg::OP_INC, id, 16'($urandom));
        sent++;
      end else if (roll < 60) begin
        case ($urandom_range(0, 3))
          0: amt = COUNT_MAX - cur;
          1: amt = COUNT_MAX - cur + 16'd1;
          2: amt = 16'($urandom_range(0, 15));
          default: amt = 16'($urandom);
        endcase
        send_item(rcid_pkg::OP_ADD, id, amt);
        sent++;
      end else if (roll < 78) begin
        send_item(rcid_pkg::OP_DEC, id, 16'($urandom));
        sent++;
      end else if (roll < 92) begin
        case ($urandom_range(0, 3))
          0: amt = cur;
          1: amt = cur + 16'd1;
          2: amt = 16'($urandom_range(0, 15));
          default: amt = 16'($urandom);
        endcase
        send_item(rcid_pkg::OP_SUB, id, amt);
        sent++;
      end else if (roll < 96) begin
        // unused codes, ignored by the block
        send_item(rcid_pkg::OP_SUB + 3'($urandom_range(1, 3)), id, 16'($urandom));
        sent++;
      end else begin
        send_item(3'($urandom), 6'($urandom), 16'($urandom));
        sent++;
      end
    end
  endtask

  task automatic test_random_traffic();
    for (int p = 0; p < 10; p++) begin
      if (p == 9) idle_on = 1'b0;
      run_random_phase(POOL_PLAN[p], PHASE_ITEMS);
    end
  endtask

  // main sequence
  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    for (int i = 0; i < MAX_POOL; i++) id_refcount[i] = '0;
    alloc_hint = '0;
    pool_cfg = rcid_pkg::POOL_RESET;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    test_directed_basics();
    test_pool_limits();
    test_backpressure();
    test_random_traffic();
    drain_results();
    repeat (70) @(negedge clk);
    if (err_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
